FILE: sv/vumsf_pkg.sv
`timescale 1ns / 1ps
// ============================================================================
// vumsf_pkg
// Shared types and constants for the vector-unit MAC/status flag keeper.
// ============================================================================
package vumsf_pkg;

    // Function codes carried in the input tuser
    typedef enum logic [1:0] {
        FUNC_CLASSIFY = 2'd0,
        FUNC_CLEAR    = 2'd1,
        FUNC_STATUS   = 2'd2,
        FUNC_NONE     = 2'd3
    } t_func;

    localparam int unsigned VALUE_W  = 32;
    localparam int unsigned MAC_W    = 16;
    localparam int unsigned STATUS_W = 12;
    localparam int unsigned LANES    = 4;

    // Largest finite magnitude, used when clamping infinities and NaNs
    localparam logic [30:0] CLAMP_MAG = 31'h7f7fffff;

    // Exponent code of infinities and NaNs
    localparam logic [7:0] EXP_MAX = 8'hff;

    // Payload of one item on its way to the flag logic
    typedef struct packed {
        t_func              func;
        logic [1:0]         lane;
        logic [VALUE_W-1:0] value;
    } t_item;

    // Result of one item
    typedef struct packed {
        logic [STATUS_W-1:0] status_flags;
        logic [MAC_W-1:0]    mac_flags;
        logic [VALUE_W-1:0]  result_value;
    } t_result;

endpackage

FILE: sv/vumsf_calc.sv
`timescale 1ns / 1ps
// ============================================================================
// vumsf_calc
// Flag update logic: classifies one value for a lane, clears a lane, or
// folds the MAC groups into the status word. Purely combinational.
// ============================================================================
module vumsf_calc
    import vumsf_pkg::*;
(
    input  t_item               i_item,
    input  logic [MAC_W-1:0]    i_mac,
    input  logic [STATUS_W-1:0] i_status,
    output t_result             o_result
);

    logic [LANES-1:0] lane_bit;
    logic [LANES-1:0] z_grp, s_grp, u_grp, o_grp;
    logic [LANES-1:0] z_nxt, s_nxt, u_nxt, o_nxt;
    logic [7:0]       exp_f;
    logic             sign_f;
    logic             mant_nz;
    logic [VALUE_W-1:0]  res_val;
    logic [STATUS_W-1:0] status_nxt;

    // x is the highest bit of each group
    assign lane_bit = 4'b1000 >> i_item.lane;

    assign z_grp = i_mac[3:0];
    assign s_grp = i_mac[7:4];
    assign u_grp = i_mac[11:8];
    assign o_grp = i_mac[15:12];

    assign sign_f  = i_item.value[31];
    assign exp_f   = i_item.value[30:23];
    assign mant_nz = |i_item.value[22:0];

    // Group updates and returned value
    always_comb begin
        z_nxt      = z_grp;
        s_nxt      = s_grp;
        u_nxt      = u_grp;
        o_nxt      = o_grp;
        res_val    = i_item.value;
        status_nxt = i_status;
        case (i_item.func)
            FUNC_CLASSIFY: begin
                s_nxt = sign_f ? (s_grp | lane_bit) : (s_grp & ~lane_bit);
                if (exp_f == 8'd0 && !mant_nz) begin
                    // signed zero
                    z_nxt = z_grp | lane_bit;
                    u_nxt = u_grp & ~lane_bit;
                    o_nxt = o_grp & ~lane_bit;
                end else if (exp_f == 8'd0) begin
                    // denormal: flush to signed zero
                    z_nxt   = z_grp | lane_bit;
                    u_nxt   = u_grp | lane_bit;
                    o_nxt   = o_grp & ~lane_bit;
                    res_val = {sign_f, 31'd0};
                end else if (exp_f == EXP_MAX) begin
                    // infinity or NaN: clamp, Z kept
                    u_nxt   = u_grp & ~lane_bit;
                    o_nxt   = o_grp | lane_bit;
                    res_val = {sign_f, CLAMP_MAG};
                end else begin
                    z_nxt = z_grp & ~lane_bit;
                    u_nxt = u_grp & ~lane_bit;
                    o_nxt = o_grp & ~lane_bit;
                end
            end
            FUNC_CLEAR: begin
                z_nxt = z_grp & ~lane_bit;
                s_nxt = s_grp & ~lane_bit;
                u_nxt = u_grp & ~lane_bit;
                o_nxt = o_grp & ~lane_bit;
            end
            FUNC_STATUS: begin
                // bits 0-3 any-group, old 0-3 to 6-9, keep 4,5,10,11
                status_nxt = {i_status[11:10], i_status[3:0], i_status[5:4],
                              |o_grp, |u_grp, |s_grp, |z_grp};
            end
            default: begin
                // unused code: nothing changes
            end
        endcase
    end

    assign o_result.result_value = res_val;
    assign o_result.mac_flags    = {o_nxt, u_nxt, s_nxt, z_nxt};
    assign o_result.status_flags = status_nxt;

endmodule

FILE: sv/vector_unit_mac_status_flags_unit.sv
`timescale 1ns / 1ps
// ============================================================================
// vector_unit_mac_status_flags_unit
// Keeps the MAC flag word and the status flag word of a vector unit.
// ============================================================================
// One item enters per clock cycle while the output side does not stall; each
// gives exactly one result item, passing through the input register and then
// the result register. The flag words are updated as an item moves from the
// input register into the result register, so a following item always sees
// the flags left by the one before it. Input tuser carries func in bits
// [1:0] and lane in bits [3:2]; tdata carries the value. Output tdata packs
// result_value, mac_flags and status_flags from bit 0 up, zero-filled to 64
// bits. A stall on the output side holds the pipeline without losing items.
// ============================================================================
module vector_unit_mac_status_flags_unit
    import vumsf_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input items
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // [31:0] value
    input  logic [3:0]  s_axis_tuser,   // [1:0] func, [3:2] lane
    // result items
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [63:0] m_axis_tdata    // [31:0] result_value, [47:32] mac_flags,
                                        // [59:48] status_flags, [63:60] zero
);

    logic                r_in_valid;
    t_item               r_in_item;
    logic                r_out_valid;
    t_result             r_out;
    logic [MAC_W-1:0]    r_mac;
    logic [STATUS_W-1:0] r_status;

    t_result             n_out;
    logic                advance;
    logic                in_take;

    // The input register moves on when the result register is free or drains
    assign advance       = !r_out_valid || m_axis_tready;
    assign s_axis_tready = !r_in_valid || advance;
    assign in_take       = s_axis_tvalid && s_axis_tready;

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in_item.func  <= t_func'(s_axis_tuser[1:0]);
            r_in_item.lane  <= s_axis_tuser[3:2];
            r_in_item.value <= s_axis_tdata;
        end
    end

    // Flag logic
    vumsf_calc u_calc (
        .i_item   (r_in_item),
        .i_mac    (r_mac),
        .i_status (r_status),
        .o_result (n_out)
    );

    // Flag words commit as the item enters the result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mac    <= '0;
            r_status <= '0;
        end else if (r_in_valid && advance) begin
            r_mac    <= n_out.mac_flags;
            r_status <= n_out.status_flags;
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && r_in_valid) begin
            r_out <= n_out;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {4'd0, r_out.status_flags, r_out.mac_flags, r_out.result_value};

endmodule

FILE: dv/tb_vector_unit_mac_status_flags_unit.sv
`timescale 1ns / 1ps
// ============================================================================
// tb_vector_unit_mac_status_flags_unit
// Self-checking bench for the vector-unit MAC/status flag keeper.
// ============================================================================
// A short table of hand-picked items (zeros, denormals, infinities, NaNs,
// lane clears, status folds, the unused code) is followed by about 550
// random items. Every accepted item runs through a local flag model that
// keeps its own MAC and status words. Each result item is compared field
// by field with the oldest expectation. Both stream sides idle at random,
// with burst stretches and one full drain in the middle of the run.
// ============================================================================
module tb_vector_unit_mac_status_flags_unit;
    import vumsf_pkg::*;

    localparam int N_RANDOM    = 550;
    localparam int IDLE_LIMIT  = 5000;
    localparam int TAIL_CYCLES = 10;

    // One row of the directed table; exp_* hold only where lit is set
    typedef struct packed {
        t_func       func;
        logic [1:0]  lane;
        logic [31:0] value;
        logic        lit;
        logic [31:0] exp_value;
        logic [15:0] exp_mac;
        logic [11:0] exp_status;
    } t_flag_row;

    localparam int N_DIRECTED = 22;
    localparam t_flag_row DIRECTED_ROWS [N_DIRECTED] = '{
        // status fold straight after reset
        '{FUNC_STATUS,   2'd0, 32'h0000_0000, 1'b1, 32'h0000_0000, 16'h0000, 12'h000},
        // +0 on x, -0 on y
        '{FUNC_CLASSIFY, 2'd0, 32'h0000_0000, 1'b1, 32'h0000_0000, 16'h0008, 12'h000},
        '{FUNC_CLASSIFY, 2'd1, 32'h8000_0000, 1'b1, 32'h8000_0000, 16'h004c, 12'h000},
        // smallest and largest denormals flush to signed zero
        '{FUNC_CLASSIFY, 2'd2, 32'h0000_0001, 1'b1, 32'h0000_0000, 16'h024e, 12'h000},
        '{FUNC_CLASSIFY, 2'd3, 32'h807f_ffff, 1'b1, 32'h8000_0000, 16'h035f, 12'h000},
        '{FUNC_STATUS,   2'd0, 32'hffff_ffff, 1'b1, 32'hffff_ffff, 16'h035f, 12'h007},
        // +inf on x, negative NaN on y: clamp, Z kept
        '{FUNC_CLASSIFY, 2'd0, 32'h7f80_0000, 1'b1, 32'h7f7f_ffff, 16'h835f, 12'h007},
        '{FUNC_CLASSIFY, 2'd1, 32'hffff_ffff, 1'b1, 32'hff7f_ffff, 16'hc35f, 12'h007},
        '{FUNC_STATUS,   2'd2, 32'h1234_5678, 1'b1, 32'h1234_5678, 16'hc35f, 12'h1cf},
        // normal value clears Z, U, O of z
        '{FUNC_CLASSIFY, 2'd2, 32'h3f80_0000, 1'b1, 32'h3f80_0000, 16'hc15d, 12'h1cf},
        // lane clears echo the value
        '{FUNC_CLEAR,    2'd3, 32'ha5a5_a5a5, 1'b1, 32'ha5a5_a5a5, 16'hc04c, 12'h1cf},
        '{FUNC_CLEAR,    2'd0, 32'h5a5a_5a5a, 1'b1, 32'h5a5a_5a5a, 16'h4044, 12'h1cf},
        // unused code leaves everything alone
        '{FUNC_NONE,     2'd1, 32'hdead_beef, 1'b1, 32'hdead_beef, 16'h4044, 12'h1cf},
        // two folds in a row shift the history
        '{FUNC_STATUS,   2'd3, 32'h0000_0000, 1'b1, 32'h0000_0000, 16'h4044, 12'h3cb},
        '{FUNC_STATUS,   2'd1, 32'h0000_0000, 1'b1, 32'h0000_0000, 16'h4044, 12'h2cb},
        // boundary normals, a quiet NaN, a negative denormal, two clears and a fold
        '{FUNC_CLASSIFY, 2'd3, 32'h0080_0000, 1'b0, 32'h0, 16'h0, 12'h0},
        '{FUNC_CLASSIFY, 2'd0, 32'h7f7f_ffff, 1'b0, 32'h0, 16'h0, 12'h0},
        '{FUNC_CLASSIFY, 2'd2, 32'h7fc0_0000, 1'b0, 32'h0, 16'h0, 12'h0},
        '{FUNC_CLASSIFY, 2'd1, 32'h8000_0001, 1'b0, 32'h0, 16'h0, 12'h0},
        '{FUNC_CLEAR,    2'd1, 32'h0000_0000, 1'b0, 32'h0, 16'h0, 12'h0},
        '{FUNC_CLEAR,    2'd2, 32'hffff_ffff, 1'b0, 32'h0, 16'h0, 12'h0},
        '{FUNC_STATUS,   2'd0, 32'h8000_0000, 1'b0, 32'h0, 16'h0, 12'h0}
    };

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata;   // [31:0] value
    logic [3:0]  s_axis_tuser;   // [1:0] func, [3:2] lane
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [63:0] m_axis_tdata;   // [31:0] result_value, [47:32] mac_flags,
                                 // [59:48] status_flags, [63:60] zero

    // Flag model state and pending results
    logic [15:0] mac_model;
    logic [11:0] status_model;
    t_result     pending_results [$];
    int          n_errors = 0;
    longint      cycle_count = 0;

    vector_unit_mac_status_flags_unit dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
    end

    // Apply one item to the flag model and return its result
    function automatic t_result apply_flag_item(input t_func f, input logic [1:0] ln,
                                                input logic [31:0] v);
        t_result     r;
        int          sh;
        logic [15:0] m;
        logic [3:0]  any;
        sh = 3 - int'(ln);
        m  = mac_model;
        r.result_value = v;
        case (f)
            FUNC_CLASSIFY: begin
                m[4 + sh] = v[31];
                if (v[30:23] == 8'd0 && v[22:0] == 23'd0) begin
                    m[12 + sh] = 1'b0;
                    m[8 + sh]  = 1'b0;
                    m[sh]      = 1'b1;
                end else if (v[30:23] == 8'd0) begin
                    // denormal: flush to signed zero, flag underflow
                    m[12 + sh] = 1'b0;
                    m[8 + sh]  = 1'b1;
                    m[sh]      = 1'b1;
                    r.result_value = {v[31], 31'd0};
                end else if (v[30:23] == EXP_MAX) begin
                    // inf/NaN: clamp, Z untouched
                    m[12 + sh] = 1'b1;
                    m[8 + sh]  = 1'b0;
                    r.result_value = {v[31], CLAMP_MAG};
                end else begin
                    m[12 + sh] = 1'b0;
                    m[8 + sh]  = 1'b0;
                    m[sh]      = 1'b0;
                end
                mac_model = m;
            end
            FUNC_CLEAR: begin
                mac_model[sh]      = 1'b0;
                mac_model[4 + sh]  = 1'b0;
                mac_model[8 + sh]  = 1'b0;
                mac_model[12 + sh] = 1'b0;
            end
            FUNC_STATUS: begin
                any = {|mac_model[15:12], |mac_model[11:8], |mac_model[7:4], |mac_model[3:0]};
                status_model = {status_model[11:10], status_model[3:0],
                                status_model[5:4], any};
            end
            default: ;
        endcase
        r.mac_flags    = mac_model;
        r.status_flags = status_model;
        return r;
    endfunction

    // Idle length: mostly none, some short, a few long; none in burst stretches
    function automatic int idle_len(input bit burst);
        int r;
        r = $urandom_range(0, 99);
        if (burst || r < 65) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // Random float pattern spread over all classes
    function automatic logic [31:0] rand_float();
        logic        s;
        logic [22:0] mant;
        logic [7:0]  ex;
        s    = 1'($urandom_range(0, 1));
        mant = 23'($urandom);
        ex   = 8'($urandom_range(1, 254));
        case ($urandom_range(0, 9))
            0:       return {s, 31'd0};
            1:       return {s, 8'd0, (mant == 23'd0) ? 23'd1 : mant};
            2:       return {s, EXP_MAX, 23'd0};
            3:       return {s, EXP_MAX, (mant == 23'd0) ? 23'd1 : mant};
            8, 9:    return $urandom;
            default: return {s, ex, mant};
        endcase
    endfunction

    // Present one item from the falling edge, wait for acceptance, record it
    task automatic send_item(input t_func f, input logic [1:0] ln, input logic [31:0] v,
                             input int gap, input logic lit, input t_result lit_res);
        t_result r;
        if (gap > 0) begin
            s_axis_tvalid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tdata  = v;
        s_axis_tuser  = {ln, f};
        do @(posedge i_clk); while (!s_axis_tready);
        r = apply_flag_item(f, ln, v);
        pending_results.push_back(lit ? lit_res : r);
        @(negedge i_clk);
    endtask

    // Result side: random back-pressure, with stretches of steady ready
    initial begin : sink_drive
        int stall_left;
        m_axis_tready = 1'b0;
        stall_left    = 0;
        forever begin
            @(negedge i_clk);
            if (stall_left > 0) begin
                m_axis_tready = 1'b0;
                stall_left--;
            end else begin
                m_axis_tready = 1'b1;
                if ($urandom_range(0, 99) < 30)
                    stall_left = idle_len((cycle_count / 150) % 3 == 2);
            end
        end
    end

    // Result checker
    always @(posedge i_clk) begin : result_check
        t_result want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pending_results.size() == 0) begin
                $error("result item with no expectation: tdata %h", m_axis_tdata);
                n_errors++;
            end else begin
                want = pending_results.pop_front();
                if (m_axis_tdata[31:0] !== want.result_value) begin
                    $error("result_value: expected %h, actual %h",
                           want.result_value, m_axis_tdata[31:0]);
                    n_errors++;
                end
                if (m_axis_tdata[47:32] !== want.mac_flags) begin
                    $error("mac_flags: expected %h, actual %h",
                           want.mac_flags, m_axis_tdata[47:32]);
                    n_errors++;
                end
                if (m_axis_tdata[59:48] !== want.status_flags) begin
                    $error("status_flags: expected %h, actual %h",
                           want.status_flags, m_axis_tdata[59:48]);
                    n_errors++;
                end
                if (m_axis_tdata[63:60] !== 4'd0) begin
                    $error("tdata pad: expected %h, actual %h", 4'd0, m_axis_tdata[63:60]);
                    n_errors++;
                end
            end
        end
    end

    // Watchdog: too long with nothing accepted on either side
    initial begin : watchdog
        int idle;
        idle = 0;
        @(posedge i_rst_n);
        while (idle < IDLE_LIMIT) begin
            @(posedge i_clk);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                idle = 0;
            else
                idle++;
        end
        $display("CHECK FAILED");
        $finish;
    end

    // Main stimulus
    initial begin : stimulus
        t_result   lit_res;
        t_result   no_res;
        t_flag_row row;
        t_func     f;
        int        sel;
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = '0;
        mac_model     = '0;
        status_model  = '0;
        no_res        = '0;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed table
        for (int i = 0; i < N_DIRECTED; i++) begin
            row = DIRECTED_ROWS[i];
            lit_res.result_value = row.exp_value;
            lit_res.mac_flags    = row.exp_mac;
            lit_res.status_flags = row.exp_status;
            send_item(row.func, row.lane, row.value, idle_len(i < 8), row.lit, lit_res);
        end

        // random items
        for (int i = 0; i < N_RANDOM; i++) begin
            if (i == N_RANDOM / 2) begin
                // hold off until the block has drained
                s_axis_tvalid = 1'b0;
                while (pending_results.size() != 0) @(negedge i_clk);
            end
            sel = $urandom_range(0, 99);
            if (sel < 50)      f = FUNC_CLASSIFY;
            else if (sel < 65) f = FUNC_CLEAR;
            else if (sel < 90) f = FUNC_STATUS;
            else               f = FUNC_NONE;
            send_item(f, 2'($urandom_range(0, 3)),
                      (f == FUNC_CLASSIFY) ? rand_float() : 32'($urandom),
                      idle_len((i / 50) % 3 == 2), 1'b0, no_res);
        end
        s_axis_tvalid = 1'b0;

        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (n_errors == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
